// File: rtl/fat12_cluster_chain_walker_defines.svh
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker: assertion macros
// Shared property forms for the walker's checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_DEFINES_SVH

// same-cycle implication
`define FCCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/fccw_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker package
// Item and result layouts, operation codes, register indexes and constants.
// ----------------------------------------------------------------------------
package fccw_pkg;

    // input operation codes
    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RESERVED_SECTORS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_COPIES        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTORS_PER_TABLE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROOT_ENTRIES        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_SECTOR    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTORS_PER_CLUSTER = 3'd5;

    localparam logic [15:0] RST_RESERVED_SECTORS    = 16'd1;
    localparam logic [2:0]  RST_TABLE_COPIES        = 3'd2;
    localparam logic [7:0]  RST_SECTORS_PER_TABLE   = 8'd9;
    localparam logic [12:0] RST_ROOT_ENTRIES        = 13'd224;
    localparam logic [12:0] RST_BYTES_PER_SECTOR    = 13'd512;
    localparam logic [7:0]  RST_SECTORS_PER_CLUSTER = 8'd1;

    // table entry constants
    localparam logic [11:0] ENTRY_MASK = 12'hFFF;
    localparam logic [11:0] END_MARK   = 12'hFF8;
    localparam logic [3:0]  NIBBLE     = 4'hF;

    // root directory size divider: (root_entries * 32) / bytes_per_sector
    localparam int DIR_W = 18;
    localparam int BPS_W = 13;

    typedef struct packed {
        logic [1:0]  op;
        logic [12:0] table_address;
        logic [7:0]  table_byte;
        logic [11:0] start_cluster;
    } item_t;

    typedef struct packed {
        logic [31:0] sector_address;
        logic [7:0]  sector_count;
        logic [11:0] next_entry;
        logic        chain_end;
        logic        bad_cluster;
    } result_t;

endpackage

// File: rtl/fat12_cluster_chain_walker.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker
// Loads a FAT12 allocation table and follows a file's cluster chain, giving
// the data sector address, sector count and next entry for each cluster.
//
//   channel   handshake              carries
//   input     push / full            opcode, table_address, table_byte,
//                                    start_cluster
//   result    empty / pop            sector_address, sector_count, next_entry,
//                                    chain_end, bad_cluster
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// A load writes the table copy from the idle state. A start makes two table
// reads per entry, low byte then high byte, and then runs the directory size
// divider; an advance first reads the current entry and steps to the next cluster.
// Reset clears the queues and sets the volume registers to their defaults;
// the table copy is not cleared.
// A full result queue holds the back end; the input queue keeps taking items until it is full.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker #(
    parameter int TABLE_BYTES = 8192,
    parameter int IN_DEPTH    = 2,
    parameter int OUT_DEPTH   = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       opcode,
    input  logic [12:0]                      table_address,
    input  logic [7:0]                       table_byte,
    input  logic [11:0]                      start_cluster,
    output logic                             empty,
    input  logic                             pop,
    output logic [31:0]                      sector_address,
    output logic [7:0]                       sector_count,
    output logic [11:0]                      next_entry,
    output logic                             chain_end,
    output logic                             bad_cluster,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fccw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fccw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    fccw_pkg::item_t   item;
    logic              item_empty;
    logic              item_pop;
    fccw_pkg::result_t res_in;
    fccw_pkg::result_t res_out;
    logic              res_push;
    logic              res_full;

    assign cfg_ready = 1'b1;

    fccw_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .table_address (table_address),
        .table_byte    (table_byte),
        .start_cluster (start_cluster),
        .item          (item),
        .item_empty    (item_empty),
        .item_pop      (item_pop)
    );

    fccw_back #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_empty (item_empty),
        .item_pop   (item_pop),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .result     (res_in),
        .res_push   (res_push),
        .res_full   (res_full)
    );

    fccw_fifo #(
        .WIDTH ($bits(fccw_pkg::result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign sector_address = res_out.sector_address;
    assign sector_count   = res_out.sector_count;
    assign next_entry     = res_out.next_entry;
    assign chain_end      = res_out.chain_end;
    assign bad_cluster    = res_out.bad_cluster;

endmodule

// File: rtl/fccw_fifo.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker: small queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module fccw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/fccw_front.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker: front end
// Accepts input items, drops unused opcodes and queues the rest for the back.
// ----------------------------------------------------------------------------
module fccw_front #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [1:0]      opcode,
    input  logic [12:0]     table_address,
    input  logic [7:0]      table_byte,
    input  logic [11:0]     start_cluster,
    output fccw_pkg::item_t item,
    output logic            item_empty,
    input  logic            item_pop
);

    fccw_pkg::item_t in_item;
    logic            keep;
    logic            q_full;

    always_comb
    begin
        in_item.op            = opcode;
        in_item.table_address = table_address;
        in_item.table_byte    = table_byte;
        in_item.start_cluster = start_cluster;
        case (opcode)
            fccw_pkg::OP_LOAD,
            fccw_pkg::OP_START,
            fccw_pkg::OP_ADVANCE: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    assign full = q_full;

    fccw_fifo #(
        .WIDTH ($bits(fccw_pkg::item_t)),
        .DEPTH (DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (in_item),
        .full    (q_full),
        .rd_en   (item_pop),
        .rd_data (item),
        .empty   (item_empty)
    );

endmodule

// File: rtl/fccw_div.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker: directory size divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module fccw_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [fccw_pkg::DIR_W-1:0]   dividend,
    input  logic [fccw_pkg::BPS_W-1:0]   divisor,
    output logic                         busy,
    output logic                         done,
    output logic [fccw_pkg::DIR_W-1:0]   quotient
);

    localparam int DW = fccw_pkg::DIR_W;
    localparam int SW = fccw_pkg::BPS_W;
    localparam int NW = $clog2(DW + 1);

    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          zero_reg, zero_next;
    logic [SW:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] dsr_reg, dsr_next;
    logic [SW:0]   shifted;
    logic          fits;

    assign shifted  = {rem_reg[SW-1:0], quo_reg[DW-1]};
    assign fits     = shifted >= {1'b0, dsr_reg};
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next  = NW'(DW);
            busy_next = 1'b1;
            zero_next = (divisor == '0);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? shifted - {1'b0, dsr_reg} : shifted;
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
    end

endmodule

// File: rtl/fccw_back.sv
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker: back end
// Holds the table copy and the volume registers, follows the chain and
// builds one result per start or productive advance.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_defines.svh"

module fccw_back #(
    parameter int TABLE_BYTES = 8192
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fccw_pkg::item_t                      item,
    input  logic                                 item_empty,
    output logic                                 item_pop,
    input  logic                                 cfg_valid,
    input  logic [fccw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fccw_pkg::CFG_DATA_W-1:0]      cfg_data,
    output fccw_pkg::result_t                    result,
    output logic                                 res_push,
    input  logic                                 res_full
);

    localparam int AW = $clog2(TABLE_BYTES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD_LO = 3'd1;
    localparam logic [2:0] ST_RD_HI = 3'd2;
    localparam logic [2:0] ST_ENTRY = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    // volume registers
    logic [15:0] rsv_reg;
    logic [2:0]  copies_reg;
    logic [7:0]  spt_reg;
    logic [12:0] root_reg;
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;

    logic [2:0]  state_reg, state_next;
    logic [11:0] cur_reg, cur_next;
    logic        finished_reg, finished_next;
    logic        adv_pass_reg, adv_pass_next;

    logic [7:0]  mem [TABLE_BYTES];
    logic [7:0]  rd_data_reg;
    logic        rd_ok_reg;
    logic [7:0]  lo_reg;

    logic [11:0] entry_reg;
    logic        end_reg;
    logic        bad_reg;
    logic [10:0] prod_a_reg;
    logic [19:0] prod_b_reg;
    logic [31:0] part_reg;

    logic [12:0] offset;
    logic [12:0] rd_addr;
    logic [31:0] rd_ext;
    logic [31:0] wr_ext;
    logic        rd_in_range;
    logic        wr_en;
    logic [7:0]  hi_byte;
    logic [11:0] entry;
    logic [11:0] cur_less2;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [fccw_pkg::DIR_W-1:0] dir_sectors;

    // byte offset of an entry: cluster * 3 / 2
    assign offset      = {1'b0, cur_reg} + {2'b00, cur_reg[11:1]};
    assign rd_addr     = (state_reg == ST_RD_HI) ? offset + 1'b1 : offset;
    assign rd_ext      = 32'(rd_addr);
    assign wr_ext      = 32'(item.table_address);
    assign rd_in_range = rd_ext < 32'(TABLE_BYTES);
    assign hi_byte     = rd_ok_reg ? rd_data_reg : 8'd0;
    assign entry       = cur_reg[0] ? {hi_byte, lo_reg[7:4]}
                                    : {hi_byte[3:0] & fccw_pkg::NIBBLE, lo_reg}
                                      & fccw_pkg::ENTRY_MASK;
    assign cur_less2   = cur_reg - 12'd2;
    assign wr_en       = (state_reg == ST_IDLE) && !item_empty
                         && (item.op == fccw_pkg::OP_LOAD)
                         && (wr_ext < 32'(TABLE_BYTES));
    assign div_start   = (state_reg == ST_ENTRY) && !adv_pass_reg;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        finished_next = finished_reg;
        adv_pass_next = adv_pass_reg;
        item_pop      = 1'b0;
        res_push      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop = 1'b1;
                    case (item.op)
                        fccw_pkg::OP_START:
                        begin
                            cur_next      = item.start_cluster;
                            adv_pass_next = 1'b0;
                            state_next    = ST_RD_LO;
                        end
                        fccw_pkg::OP_ADVANCE:
                        begin
                            // drop an advance once the chain is over
                            if (!finished_reg)
                            begin
                                adv_pass_next = 1'b1;
                                state_next    = ST_RD_LO;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_LO:
            begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                state_next = ST_ENTRY;
            end
            ST_ENTRY:
            begin
                if (adv_pass_reg)
                begin
                    // step to the next cluster, then read its own entry
                    cur_next      = entry;
                    adv_pass_next = 1'b0;
                    state_next    = ST_RD_LO;
                end
                else
                begin
                    finished_next = (entry >= fccw_pkg::END_MARK) || (cur_reg < 12'd2);
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_reg      <= '0;
            finished_reg <= 1'b1;
            adv_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            finished_reg <= finished_next;
            adv_pass_reg <= adv_pass_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsv_reg    <= fccw_pkg::RST_RESERVED_SECTORS;
            copies_reg <= fccw_pkg::RST_TABLE_COPIES;
            spt_reg    <= fccw_pkg::RST_SECTORS_PER_TABLE;
            root_reg   <= fccw_pkg::RST_ROOT_ENTRIES;
            bps_reg    <= fccw_pkg::RST_BYTES_PER_SECTOR;
            spc_reg    <= fccw_pkg::RST_SECTORS_PER_CLUSTER;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fccw_pkg::REG_RESERVED_SECTORS:    rsv_reg    <= cfg_data;
                fccw_pkg::REG_TABLE_COPIES:        copies_reg <= cfg_data[2:0];
                fccw_pkg::REG_SECTORS_PER_TABLE:   spt_reg    <= cfg_data[7:0];
                fccw_pkg::REG_ROOT_ENTRIES:        root_reg   <= cfg_data[12:0];
                fccw_pkg::REG_BYTES_PER_SECTOR:    bps_reg    <= cfg_data[12:0];
                fccw_pkg::REG_SECTORS_PER_CLUSTER: spc_reg    <= cfg_data[7:0];
                default:                           rsv_reg    <= rsv_reg;
            endcase
        end
    end

    // table copy: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ext[AW-1:0]] <= item.table_byte;
        end
        rd_data_reg <= mem[rd_ext[AW-1:0]];
        rd_ok_reg   <= rd_in_range;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD_HI)
        begin
            lo_reg <= rd_ok_reg ? rd_data_reg : 8'd0;
        end
        if (div_start)
        begin
            entry_reg  <= entry;
            end_reg    <= entry >= fccw_pkg::END_MARK;
            bad_reg    <= cur_reg < 12'd2;
            prod_a_reg <= copies_reg * spt_reg;
            prod_b_reg <= cur_less2 * spc_reg;
        end
        if (state_reg == ST_DIV)
        begin
            part_reg <= 32'(rsv_reg) + 32'(prod_a_reg) + 32'(prod_b_reg);
        end
    end

    fccw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({root_reg, 5'b00000}),
        .divisor  (bps_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (dir_sectors)
    );

    always_comb
    begin
        result.sector_address = bad_reg ? 32'd0 : part_reg + 32'(dir_sectors);
        result.sector_count   = spc_reg;
        result.next_entry     = entry_reg;
        result.chain_end      = end_reg;
        result.bad_cluster    = bad_reg;
    end

    `FCCW_ASSERT_NEXT(a_div_runs, clk, rst_n, div_start, div_busy,
        "divider did not start")
    `FCCW_ASSERT_NEXT(a_load_stays_idle, clk, rst_n,
        (state_reg == ST_IDLE) && item_pop && (item.op == fccw_pkg::OP_LOAD),
        state_reg == ST_IDLE, "load left the idle state")
    `FCCW_ASSERT_NOW(a_push_only_fin, clk, rst_n, res_push,
        (state_reg == ST_FIN) && !res_full, "result pushed outside finish")
    `FCCW_ASSERT_NOW(a_bad_zero_addr, clk, rst_n, res_push && bad_reg,
        result.sector_address == 32'd0, "bad cluster with nonzero address")

endmodule
